@@ rtl/core/larc_pkg.sv @@
// ----------------------------------------------------------------------------
// larc_pkg
// Shared types and constants for the lazy adaptive replacement cache.
// ----------------------------------------------------------------------------
package larc_pkg;

  localparam int CNT_WIDTH = 32;
  localparam int CAP_WIDTH = 7;
  localparam int MODE_WIDTH = 2;
  localparam int NUM_COUNTERS = 6;

  // request kinds
  localparam logic [MODE_WIDTH-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_WRITE = 2'd1;

  // event counter slots
  localparam int CNT_HIT        = 0;
  localparam int CNT_MISS       = 1;
  localparam int CNT_READ_HIT   = 2;
  localparam int CNT_WRITE_HIT  = 3;
  localparam int CNT_READ_MISS  = 4;
  localparam int CNT_WRITE_MISS = 5;

  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  // what one cell loads on the next edge
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_FROM_PREV,
    SEL_FROM_NEXT,
    SEL_CLEAR
  } sel_t;

  // what a row of cells does on the next edge
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_TOUCH,
    CMD_REMOVE,
    CMD_INSERT
  } cmd_t;

  typedef struct packed {
    logic capture;
    cmd_t cmd;
  } row_ctl_t;

  function automatic logic [CNT_WIDTH-1:0] sat_inc(input logic [CNT_WIDTH-1:0] v);
    sat_inc = (v == {CNT_WIDTH{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

@@ rtl/core/larc_cell.sv @@
// ----------------------------------------------------------------------------
// larc_cell
// One recency slot: holds a key and a valid bit, compares against the probe.
// ----------------------------------------------------------------------------
module larc_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  larc_pkg::sel_t       sel,
  input  logic [KEY_WIDTH-1:0] probe,
  input  logic [KEY_WIDTH-1:0] prev_key,
  input  logic                 prev_valid,
  input  logic [KEY_WIDTH-1:0] next_key,
  input  logic                 next_valid,
  output logic [KEY_WIDTH-1:0] cell_key,
  output logic                 cell_valid,
  output logic                 match
);

  assign match = cell_valid && (cell_key == probe);

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else begin
      unique case (sel)
        larc_pkg::SEL_FROM_PREV: cell_valid <= prev_valid;
        larc_pkg::SEL_FROM_NEXT: cell_valid <= next_valid;
        larc_pkg::SEL_CLEAR:     cell_valid <= 1'b0;
        default:                 cell_valid <= cell_valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (sel)
      larc_pkg::SEL_FROM_PREV: cell_key <= prev_key;
      larc_pkg::SEL_FROM_NEXT: cell_key <= next_key;
      default:                 cell_key <= cell_key;
    endcase
  end

endmodule

@@ rtl/core/larc_row.sv @@
// ----------------------------------------------------------------------------
// larc_row
// Recency-ordered row of cells; cell 0 is most recent, valid cells form a prefix.
// ----------------------------------------------------------------------------
module larc_row #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  localparam int LW       = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  larc_pkg::row_ctl_t   ctl,
  input  logic [KEY_WIDTH-1:0] probe,
  input  logic [LW-1:0]        limit,
  output logic                 hit
);

  logic [KEY_WIDTH-1:0] keys [DEPTH];
  logic [DEPTH-1:0]     valids;
  logic [DEPTH-1:0]     slot_hits;
  logic [DEPTH-1:0]     match_q;
  logic [DEPTH-1:0]     at_or_above;
  logic [DEPTH-1:0]     at_or_below;
  larc_pkg::sel_t       sels [DEPTH];

  // capture the compare result of the search cycle
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match_q <= slot_hits;
    end
  end

  assign hit = |match_q;

  // parallel-prefix ORs: a match at or above / at or below each slot
  always_comb begin
    at_or_above = match_q;
    at_or_below = match_q;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      at_or_above = at_or_above | (at_or_above >> s);
      at_or_below = at_or_below | (at_or_below << s);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] p_key;
    logic                 p_valid;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 n_valid;

    if (i == 0) begin : g_head
      assign p_key   = probe;
      assign p_valid = 1'b1;
    end else begin : g_body
      assign p_key   = keys[i-1];
      assign p_valid = valids[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_key   = '0;
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_key   = keys[i+1];
      assign n_valid = valids[i+1];
    end

    always_comb begin
      unique case (ctl.cmd)
        larc_pkg::CMD_TOUCH:
          sels[i] = at_or_above[i] ? larc_pkg::SEL_FROM_PREV : larc_pkg::SEL_HOLD;
        larc_pkg::CMD_REMOVE:
          sels[i] = at_or_below[i] ? larc_pkg::SEL_FROM_NEXT : larc_pkg::SEL_HOLD;
        larc_pkg::CMD_INSERT:
          sels[i] = (32'(i) < 32'(limit)) ? larc_pkg::SEL_FROM_PREV : larc_pkg::SEL_CLEAR;
        default:
          sels[i] = larc_pkg::SEL_HOLD;
      endcase
    end

    larc_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .sel        (sels[i]),
      .probe      (probe),
      .prev_key   (p_key),
      .prev_valid (p_valid),
      .next_key   (n_key),
      .next_valid (n_valid),
      .cell_key   (keys[i]),
      .cell_valid (valids[i]),
      .match      (slot_hits[i])
    );
  end

endmodule

@@ rtl/core/lazy_adaptive_cache_replacement.sv @@
// ----------------------------------------------------------------------------
// lazy_adaptive_cache_replacement
// Lazy adaptive replacement cache: recency-ordered resident row, ghost row
// for lazy admission, and six saturating hit/miss counters.
// ----------------------------------------------------------------------------
//
//  channel   signals                              word
//  -------   ----------------------------------   ------------------------------
//  in        in_valid / in_ready                  key, mode
//  out       out_valid / out_ready                hit, admitted, six totals
//  cfg       cfg_valid / cfg_ready (always high)  cfg_data = capacity
//
//  Each word passes a search cycle, which compares the key against every
//  cell of both rows and registers the match vectors, then an update cycle
//  that shifts the rows and bumps the counters. The next word is taken in the
//  update cycle, so a new word enters while the last one is finishing.
//  Reset (rst, synchronous) empties both rows at once through their valid
//  bits, zeroes the counters and sets capacity to 64.
//  A stalled out channel holds the update cycle; the in channel then waits.
//
module lazy_adaptive_cache_replacement #(
  parameter int CACHE_DEPTH = 64,
  parameter int GHOST_DEPTH = 32,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [KEY_WIDTH-1:0]              key,
  input  logic [larc_pkg::MODE_WIDTH-1:0]   mode,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic                              admitted,
  output logic [larc_pkg::CNT_WIDTH-1:0]    hit_total,
  output logic [larc_pkg::CNT_WIDTH-1:0]    miss_total,
  output logic [larc_pkg::CNT_WIDTH-1:0]    read_hit_total,
  output logic [larc_pkg::CNT_WIDTH-1:0]    write_hit_total,
  output logic [larc_pkg::CNT_WIDTH-1:0]    read_miss_total,
  output logic [larc_pkg::CNT_WIDTH-1:0]    write_miss_total,
  // capacity register
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [larc_pkg::CAP_WIDTH-1:0]    cfg_data
);

  localparam int CLW = $clog2(CACHE_DEPTH + 1);
  localparam int GLW = $clog2(GHOST_DEPTH + 1);

  larc_pkg::state_t               state;
  larc_pkg::state_t               state_next;
  logic [larc_pkg::CAP_WIDTH-1:0] capacity;
  logic [KEY_WIDTH-1:0]           key_q;
  logic [larc_pkg::MODE_WIDTH-1:0] mode_q;
  logic [larc_pkg::CNT_WIDTH-1:0] counters [larc_pkg::NUM_COUNTERS];

  logic                           in_accept;
  logic                           can_finish;
  logic                           cache_hit;
  logic                           ghost_hit;
  logic [CLW-1:0]                 cache_limit;
  logic [CLW-1:0]                 half_cap;
  logic [GLW-1:0]                 ghost_limit;
  larc_pkg::row_ctl_t             cache_ctl;
  larc_pkg::row_ctl_t             ghost_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= larc_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // Effective capacity: zero acts as one, clamp to the row depth.
  always_comb begin
    if (capacity == '0) begin
      cache_limit = CLW'(1);
    end else if (32'(capacity) > 32'(CACHE_DEPTH)) begin
      cache_limit = CLW'(CACHE_DEPTH);
    end else begin
      cache_limit = CLW'(capacity);
    end
    half_cap = cache_limit >> 1;
    if (32'(half_cap) > 32'(GHOST_DEPTH)) begin
      ghost_limit = GLW'(GHOST_DEPTH);
    end else begin
      ghost_limit = GLW'(half_cap);
    end
  end

  // Sequencer: search, then update; take the next word in the update cycle.
  assign can_finish = (state == larc_pkg::S_UPDATE) && (!out_valid || out_ready);
  assign in_ready   = (state == larc_pkg::S_IDLE) || can_finish;
  assign in_accept  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      larc_pkg::S_IDLE: begin
        if (in_accept) state_next = larc_pkg::S_SEARCH;
      end
      larc_pkg::S_SEARCH: begin
        state_next = larc_pkg::S_UPDATE;
      end
      larc_pkg::S_UPDATE: begin
        if (can_finish) state_next = in_accept ? larc_pkg::S_SEARCH : larc_pkg::S_IDLE;
      end
      default: state_next = larc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= larc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      key_q  <= key;
      mode_q <= mode;
    end
  end

  // Row commands. A resident hit moves to front; a ghost hit leaves the
  // ghost row and enters the cache, trimming to capacity; any other miss
  // only records the key in the ghost row, trimmed to the ghost limit, if nonzero.
  always_comb begin
    cache_ctl.capture = (state == larc_pkg::S_SEARCH);
    ghost_ctl.capture = (state == larc_pkg::S_SEARCH);
    cache_ctl.cmd     = larc_pkg::CMD_HOLD;
    ghost_ctl.cmd     = larc_pkg::CMD_HOLD;
    if (can_finish) begin
      if (cache_hit) begin
        cache_ctl.cmd = larc_pkg::CMD_TOUCH;
      end else if (ghost_hit) begin
        ghost_ctl.cmd = larc_pkg::CMD_REMOVE;
        cache_ctl.cmd = larc_pkg::CMD_INSERT;
      end else if (ghost_limit != '0) begin
        ghost_ctl.cmd = larc_pkg::CMD_INSERT;
      end
    end
  end

  larc_row #(
    .DEPTH     (CACHE_DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cache_row (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cache_ctl),
    .probe (key_q),
    .limit (cache_limit),
    .hit   (cache_hit)
  );

  larc_row #(
    .DEPTH     (GHOST_DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ghost_row (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ghost_ctl),
    .probe (key_q),
    .limit (ghost_limit),
    .hit   (ghost_hit)
  );

  // Saturating counters; they double as the totals of the pending result,
  // since the next update waits until that result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < larc_pkg::NUM_COUNTERS; c++) begin
        counters[c] <= '0;
      end
    end else if (can_finish) begin
      if (cache_hit) begin
        counters[larc_pkg::CNT_HIT] <= larc_pkg::sat_inc(counters[larc_pkg::CNT_HIT]);
        if (mode_q == larc_pkg::MODE_READ) begin
          counters[larc_pkg::CNT_READ_HIT] <=
            larc_pkg::sat_inc(counters[larc_pkg::CNT_READ_HIT]);
        end else if (mode_q == larc_pkg::MODE_WRITE) begin
          counters[larc_pkg::CNT_WRITE_HIT] <=
            larc_pkg::sat_inc(counters[larc_pkg::CNT_WRITE_HIT]);
        end
      end else begin
        counters[larc_pkg::CNT_MISS] <= larc_pkg::sat_inc(counters[larc_pkg::CNT_MISS]);
        if (mode_q == larc_pkg::MODE_READ) begin
          counters[larc_pkg::CNT_READ_MISS] <=
            larc_pkg::sat_inc(counters[larc_pkg::CNT_READ_MISS]);
        end else if (mode_q == larc_pkg::MODE_WRITE) begin
          counters[larc_pkg::CNT_WRITE_MISS] <=
            larc_pkg::sat_inc(counters[larc_pkg::CNT_WRITE_MISS]);
        end
      end
    end
  end

  // Result flags: hold until the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_finish) begin
      hit      <= cache_hit;
      admitted <= !cache_hit && ghost_hit;
    end
  end

  assign hit_total        = counters[larc_pkg::CNT_HIT];
  assign miss_total       = counters[larc_pkg::CNT_MISS];
  assign read_hit_total   = counters[larc_pkg::CNT_READ_HIT];
  assign write_hit_total  = counters[larc_pkg::CNT_WRITE_HIT];
  assign read_miss_total  = counters[larc_pkg::CNT_READ_MISS];
  assign write_miss_total = counters[larc_pkg::CNT_WRITE_MISS];

  // A key is never both resident and admitted in one result.
  a_hit_xor_admit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && admitted))
    else $error("hit and admitted both set");

  // A result word appears only out of an update cycle.
  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == larc_pkg::S_UPDATE))
    else $error("result raised outside update");

  // Per-kind hit counts never pass the overall hit count.
  a_hit_split: assert property (@(posedge clk) disable iff (rst)
    (read_hit_total <= hit_total) && (write_hit_total <= hit_total))
    else $error("per-kind hit count above total");

  // Totals never move while a result is waiting to be taken.
  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(hit_total) && $stable(miss_total))
    else $error("totals changed under a pending result");

endmodule
